// File: src/kps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_pkg: shared types and constants of the keyed phase sampler
// Hash constants, pipeline depths, register indexes, the item types and the remainder step.
// ----------------------------------------------------------------------------
package kps_pkg;

   localparam logic [63:0] KEY_MULT  = 64'h517cc1b727220a95;
   localparam logic [63:0] MIX_ADD   = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

   localparam int HASH_STAGES = 7;
   localparam int MOD_STAGES  = 64;
   // Input register, queue slot, hash stages, remainder stages, result register.
   localparam int KPS_LATENCY = 2 + HASH_STAGES + MOD_STAGES + 1;

   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_SEED         = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INTERVAL     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_THREAD_INDEX = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_THREAD_COUNT = 8'd3;

   typedef enum logic [1:0] {
      CLS_NEVER,
      CLS_ALWAYS,
      CLS_HASH
   } cls_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DIV,
      PH_MUL,
      PH_MOD
   } phase_state_type;

   typedef struct packed {
      logic [63:0] seed;
      logic [31:0] interval;
      logic [31:0] thread_index;
      logic [31:0] thread_count;
   } cfg_type;

   typedef struct packed {
      logic [31:0] key_id;
      logic [63:0] occurrence;
      cls_type     cls;
   } item_type;

   // One restoring remainder step: shift in one dividend bit, subtract the
   // divisor when it fits. Bit 32 is the quotient bit.
   function automatic logic [32:0] rem_step(input logic [31:0] rem, input logic din,
                                            input logic [31:0] dvs);
      logic [32:0] t;
      t = {rem, din};
      if (t >= {1'b0, dvs}) begin
         rem_step = {1'b1, 32'(t - {1'b0, dvs})};
      end else begin
         rem_step = {1'b0, t[31:0]};
      end
   endfunction

endpackage

// File: src/keyed_phase_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_phase_sampler_core: per-access hash sampler
// Decides whether one occurrence of a key is sampled, from a seeded
// splitmix64 hash of the key and a per-thread phase within the interval.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                         Direction  Beat taken when
//  req      start, busy, req_*            in         start && !busy
//  rsp      rsp_valid, rsp_sample         out        rsp_valid (one cycle)
//  csr      csr_valid, csr_ready, csr_*   in         csr_valid && csr_ready
//
// A beat is accepted every cycle while busy is low; its result beat passes
// through the input register, the queue slot, the seven hash stages, the
// 64-stage one-bit-per-stage remainder pipeline and the result register.
// A write to interval, thread_index or thread_count restarts the phase
// sequencer, which holds busy and csr_ready off through its 32 divide
// steps, one multiply and 64 remainder steps. No such run follows reset
// release: reset leaves a phase of zero.
// The receiver cannot stall, so the pipeline never holds; the queue between
// the input register and the pipeline therefore never fills.
//
module keyed_phase_sampler_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [31:0]                     req_key_id,
   input  logic [63:0]                     req_occurrence,
   output logic                            rsp_valid,
   output logic                            rsp_sample,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_wdata
);
   import kps_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type front_ff, front_in;
   logic     front_v_ff;
   logic     req_take, csr_take, phase_trig;
   logic     phase_busy, q_empty, q_full;
   logic [31:0] tphase;
   item_type q_head;

   assign req_take  = start && !busy;
   assign csr_take  = csr_valid && csr_ready;
   assign csr_ready = !phase_busy;
   assign busy      = phase_busy || q_full;

   // Register write decode; a write to any phase input restarts the sequencer.
   always_comb begin
      cfg_in     = cfg_ff;
      phase_trig = 1'b0;
      if (csr_take) begin
         unique case (csr_index)
            REG_SEED: cfg_in.seed = csr_wdata;
            REG_INTERVAL: begin
               cfg_in.interval = csr_wdata[31:0];
               phase_trig      = 1'b1;
            end
            REG_THREAD_INDEX: begin
               cfg_in.thread_index = csr_wdata[31:0];
               phase_trig          = 1'b1;
            end
            REG_THREAD_COUNT: begin
               cfg_in.thread_count = csr_wdata[31:0];
               phase_trig          = 1'b1;
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Front end: capture the beat and classify the special intervals.
   always_comb begin
      front_in.key_id     = req_key_id;
      front_in.occurrence = req_occurrence;
      if (cfg_ff.interval == 32'd0) begin
         front_in.cls = CLS_NEVER;
      end else if (cfg_ff.interval == 32'd1) begin
         front_in.cls = CLS_ALWAYS;
      end else begin
         front_in.cls = CLS_HASH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= '{seed: 64'd0, interval: 32'd0, thread_index: 32'd0,
                         thread_count: 32'd1};
         front_v_ff <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         front_v_ff <= req_take;
      end
      if (req_take) front_ff <= front_in;
   end

   kps_phase u_phase (
      .clock   (clock),
      .reset   (reset),
      .trigger (phase_trig),
      .cfg     (cfg_in),
      .busy    (phase_busy),
      .tphase  (tphase)
   );

   kps_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_v_ff),
      .push_item (front_ff),
      .pop       (!q_empty),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   kps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .tphase     (tphase),
      .in_valid   (!q_empty),
      .in_item    (q_head),
      .out_valid  (rsp_valid),
      .out_sample (rsp_sample)
   );

endmodule

// File: src/kps_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_phase: thread phase sequencer
// Recomputes (thread_index * stride) mod interval one bit per cycle.
// ----------------------------------------------------------------------------
module kps_phase (
   input  logic            clock,
   input  logic            reset,
   input  logic            trigger,
   input  kps_pkg::cfg_type cfg,
   output logic            busy,
   output logic [31:0]     tphase
);
   import kps_pkg::*;

   phase_state_type state_ff, state_in;
   logic [63:0] work_ff, work_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] tphase_ff, tphase_in;
   logic [31:0] threads;
   logic [31:0] stride;
   logic [32:0] div_step;
   logic [32:0] mod_step;

   assign threads  = (cfg.thread_count == 32'd0) ? 32'd1 : cfg.thread_count;
   assign stride   = (work_ff[31:0] == 32'd0) ? 32'd1 : work_ff[31:0];
   assign div_step = rem_step(rem_ff, work_ff[31], threads);
   assign mod_step = rem_step(rem_ff, work_ff[63], cfg.interval);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= PH_IDLE;
         tphase_ff <= 32'd0;
         cnt_ff    <= 6'd0;
      end else begin
         state_ff  <= state_in;
         tphase_ff <= tphase_in;
         cnt_ff    <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   always_comb begin
      state_in  = state_ff;
      work_in   = work_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      tphase_in = tphase_ff;
      unique case (state_ff)
         PH_IDLE: begin
            if (trigger) begin
               state_in = PH_DIV;
               work_in  = {32'd0, cfg.interval};
               rem_in   = 32'd0;
               cnt_in   = 6'd0;
            end
         end
         PH_DIV: begin
            rem_in  = div_step[31:0];
            work_in = {32'd0, work_ff[30:0], div_step[32]};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               state_in = PH_MUL;
            end
         end
         PH_MUL: begin
            work_in  = 64'(cfg.thread_index * stride);
            rem_in   = 32'd0;
            cnt_in   = 6'd0;
            state_in = PH_MOD;
         end
         PH_MOD: begin
            rem_in  = mod_step[31:0];
            work_in = {work_ff[62:0], 1'b0};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               tphase_in = mod_step[31:0];
               state_in  = PH_IDLE;
            end
         end
         default: state_in = PH_IDLE;
      endcase
   end

   assign busy   = (state_ff != PH_IDLE);
   assign tphase = tphase_ff;

endmodule

// File: src/kps_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_fifo: two-entry item queue
// Show-ahead queue between the front end and the execution pipeline.
// ----------------------------------------------------------------------------
module kps_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kps_pkg::item_type push_item,
   input  logic              pop,
   output kps_pkg::item_type head,
   output logic              empty,
   output logic              full
);
   import kps_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign empty   = (cnt_ff == 2'd0);
   assign full    = (cnt_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= ~wr_ff;
         if (do_pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
      if (do_push) mem_ff[wr_ff] <= push_item;
   end

endmodule

// File: src/kps_mod_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_mod_pipe: two-lane pipelined remainder
// Reduces two 64-bit values modulo the interval, one bit per stage.
// ----------------------------------------------------------------------------
module kps_mod_pipe (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      divisor,
   input  logic             in_valid,
   input  kps_pkg::cls_type in_cls,
   input  logic [63:0]      in_a,
   input  logic [63:0]      in_b,
   output logic             out_valid,
   output kps_pkg::cls_type out_cls,
   output logic [31:0]      rem_a,
   output logic [31:0]      rem_b
);
   import kps_pkg::*;

   logic        v_ff   [MOD_STAGES];
   cls_type     cls_ff [MOD_STAGES];
   logic [63:0] da_ff  [MOD_STAGES];
   logic [63:0] db_ff  [MOD_STAGES];
   logic [31:0] ra_ff  [MOD_STAGES];
   logic [31:0] rb_ff  [MOD_STAGES];

   for (genvar s = 0; s < MOD_STAGES; s++) begin : g_stage
      logic        v_src;
      cls_type     cls_src;
      logic [63:0] da_src, db_src;
      logic [31:0] ra_src, rb_src;
      logic [32:0] step_a, step_b;

      if (s == 0) begin : g_first
         assign v_src   = in_valid;
         assign cls_src = in_cls;
         assign da_src  = in_a;
         assign db_src  = in_b;
         assign ra_src  = 32'd0;
         assign rb_src  = 32'd0;
      end else begin : g_next
         assign v_src   = v_ff[s-1];
         assign cls_src = cls_ff[s-1];
         assign da_src  = da_ff[s-1];
         assign db_src  = db_ff[s-1];
         assign ra_src  = ra_ff[s-1];
         assign rb_src  = rb_ff[s-1];
      end

      assign step_a = rem_step(ra_src, da_src[63], divisor);
      assign step_b = rem_step(rb_src, db_src[63], divisor);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_src;
         end
         cls_ff[s] <= cls_src;
         da_ff[s]  <= {da_src[62:0], 1'b0};
         db_ff[s]  <= {db_src[62:0], 1'b0};
         ra_ff[s]  <= step_a[31:0];
         rb_ff[s]  <= step_b[31:0];
      end
   end

   assign out_valid = v_ff[MOD_STAGES-1];
   assign out_cls   = cls_ff[MOD_STAGES-1];
   assign rem_a     = ra_ff[MOD_STAGES-1];
   assign rem_b     = rb_ff[MOD_STAGES-1];

endmodule

// File: src/kps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_back: execution pipeline
// Key hash, remainder pipeline and the final phase compare.
// ----------------------------------------------------------------------------
module kps_back (
   input  logic              clock,
   input  logic              reset,
   input  kps_pkg::cfg_type  cfg,
   input  logic [31:0]       tphase,
   input  logic              in_valid,
   input  kps_pkg::item_type in_item,
   output logic              out_valid,
   output logic              out_sample
);
   import kps_pkg::*;

   logic        v_ff   [HASH_STAGES];
   cls_type     cls_ff [HASH_STAGES];
   logic [63:0] occ_ff [HASH_STAGES];

   // Product partials and hash values per stage.
   logic [63:0] p0_ff, p0_in;
   logic [31:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [63:0] m_ff, m_in;
   logic [63:0] y_ff, y_in;
   logic [63:0] q0_ff, q0_in;
   logic [31:0] q1_ff, q1_in, q2_ff, q2_in;
   logic [63:0] w_ff, w_in;
   logic [63:0] r0_ff, r0_in;
   logic [31:0] r1_ff, r1_in, r2_ff, r2_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] key1, x, z, u;

   logic        mv;
   cls_type     mcls;
   logic [31:0] kphase, omod;
   logic [32:0] sum, sum_red;
   logic        valid_ff, sample_ff;

   always_comb begin
      key1  = {32'd0, in_item.key_id} + 64'd1;
      p0_in = 64'(key1[31:0] * KEY_MULT[31:0]);
      p1_in = 32'(key1[63:32] * KEY_MULT[31:0]);
      p2_in = 32'(key1[31:0] * KEY_MULT[63:32]);
      m_in  = p0_ff + {p1_ff + p2_ff, 32'd0};
      x     = (cfg.seed ^ m_ff) + MIX_ADD;
      y_in  = x ^ (x >> 30);
      q0_in = 64'(y_ff[31:0] * MIX_MUL_A[31:0]);
      q1_in = 32'(y_ff[63:32] * MIX_MUL_A[31:0]);
      q2_in = 32'(y_ff[31:0] * MIX_MUL_A[63:32]);
      z     = q0_ff + {q1_ff + q2_ff, 32'd0};
      w_in  = z ^ (z >> 27);
      r0_in = 64'(w_ff[31:0] * MIX_MUL_B[31:0]);
      r1_in = 32'(w_ff[63:32] * MIX_MUL_B[31:0]);
      r2_in = 32'(w_ff[31:0] * MIX_MUL_B[63:32]);
      u     = r0_ff + {r1_ff + r2_ff, 32'd0};
      h_in  = u ^ (u >> 31);
   end

   always_ff @(posedge clock) begin
      p0_ff <= p0_in;  p1_ff <= p1_in;  p2_ff <= p2_in;
      m_ff  <= m_in;
      y_ff  <= y_in;
      q0_ff <= q0_in;  q1_ff <= q1_in;  q2_ff <= q2_in;
      w_ff  <= w_in;
      r0_ff <= r0_in;  r1_ff <= r1_in;  r2_ff <= r2_in;
      h_ff  <= h_in;
   end

   for (genvar s = 0; s < HASH_STAGES; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= (s == 0) ? in_valid : v_ff[(s == 0) ? 0 : s-1];
         end
         cls_ff[s] <= (s == 0) ? in_item.cls : cls_ff[(s == 0) ? 0 : s-1];
         occ_ff[s] <= (s == 0) ? in_item.occurrence : occ_ff[(s == 0) ? 0 : s-1];
      end
   end

   kps_mod_pipe u_mod (
      .clock     (clock),
      .reset     (reset),
      .divisor   (cfg.interval),
      .in_valid  (v_ff[HASH_STAGES-1]),
      .in_cls    (cls_ff[HASH_STAGES-1]),
      .in_a      (h_ff),
      .in_b      (occ_ff[HASH_STAGES-1]),
      .out_valid (mv),
      .out_cls   (mcls),
      .rem_a     (kphase),
      .rem_b     (omod)
   );

   assign sum     = {1'b0, kphase} + {1'b0, tphase};
   assign sum_red = (sum >= {1'b0, cfg.interval}) ? sum - {1'b0, cfg.interval} : sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= mv;
      end
      case (mcls)
         CLS_NEVER:  sample_ff <= 1'b0;
         CLS_ALWAYS: sample_ff <= 1'b1;
         default:    sample_ff <= (sum_red[31:0] == omod);
      endcase
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;

endmodule

// File: src/kps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_checker: port-level checks of the keyed phase sampler
// Fixed result latency and configuration busy behavior.
// ----------------------------------------------------------------------------
module kps_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [kps_pkg::CSR_INDEX_W-1:0] csr_index
);
   import kps_pkg::*;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##KPS_LATENCY rsp_valid)
      else $error("accepted beat produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##KPS_LATENCY !rsp_valid)
      else $error("result without an accepted beat");

   a_phase_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index == REG_INTERVAL ||
       csr_index == REG_THREAD_INDEX || csr_index == REG_THREAD_COUNT)) |=> busy)
      else $error("phase write did not raise busy");

   a_csr_busy: assert property (@(posedge clock) disable iff (reset)
      !csr_ready |-> busy)
      else $error("csr stalled while not busy");

endmodule

bind keyed_phase_sampler_core kps_checker u_kps_checker (.*);
